>>> src/hwck_pkg.sv
// ----------------------------------------------------------------------------
// hwck_pkg
// Shared types and constants of the hue window chroma key pipeline.
// ----------------------------------------------------------------------------
package hwck_pkg;

    localparam int CH_W     = 8;    // pixel channel width
    localparam int T_W      = 11;   // offset hue numerator, 0..6*255
    localparam int NUM_W    = 17;   // 60*t + d, 0..92055
    localparam int DEN_W    = 9;    // 2*d, 0..510
    localparam int DIV_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int QUO_W    = DIV_STAGES * DIV_BITS_PER_STAGE;

    localparam logic [7:0] HUE_RANGE   = 8'd180;
    localparam logic [7:0] HUE_SHIFT   = 8'd30;
    localparam logic [6:0] TOL_MAX     = 7'd89;
    localparam logic [7:0] KEY_HUE_RST = 8'd60;
    localparam logic [6:0] HUE_TOL_RST = 7'd10;
    localparam logic [7:0] LOW_RST     = 8'd50;
    localparam logic [7:0] HIGH_RST    = 8'd70;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_TOL = 1'b1;

    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } t_max_sel;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [DEN_W-1:0] rem;     // partial remainder
        logic [QUO_W-1:0] num_lo;  // numerator bits still to shift in
        logic [DEN_W-1:0] den;     // divisor 2*d
        logic [QUO_W-1:0] quo;     // quotient bits so far
        logic             grey;    // d == 0, hue forced to 0
        t_pixel           fg;
        t_pixel           bg;
    } t_div_data;

endpackage

>>> src/hwck_hue_front.sv
// ----------------------------------------------------------------------------
// hwck_hue_front
// Two pipeline stages: channel max/min and range, then the hue numerator and
// the divider setup.
// ----------------------------------------------------------------------------
module hwck_hue_front
    import hwck_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_pixel    i_fg,
    input  t_pixel    i_bg,
    output logic      o_valid,
    output t_div_data o_data,
    input  logic      i_ready
);

    logic            r_a_valid;
    logic [CH_W-1:0] r_a_d;
    t_max_sel        r_a_sel;
    t_pixel          r_a_fg;
    t_pixel          r_a_bg;

    logic            r_b_valid;
    t_div_data       r_b_data;

    logic            w_ready_a;
    logic            w_ready_b;
    logic [CH_W-1:0] w_max;
    logic [CH_W-1:0] w_min;
    t_max_sel        w_sel;
    logic [T_W-1:0]  w_t;
    logic [T_W-1:0]  w_d;
    logic [NUM_W-1:0] w_num;
    t_div_data       n_b_data;

    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // Stage A: max with red winning ties, then green.
    always_comb begin
        w_max = i_fg.red;
        w_sel = MAX_RED;
        if (i_fg.green > w_max) begin
            w_max = i_fg.green;
            w_sel = MAX_GREEN;
        end
        if (i_fg.blue > w_max) begin
            w_max = i_fg.blue;
            w_sel = MAX_BLUE;
        end
        w_min = i_fg.red;
        if (i_fg.green < w_min) begin
            w_min = i_fg.green;
        end
        if (i_fg.blue < w_min) begin
            w_min = i_fg.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_d   <= w_max - w_min;
            r_a_sel <= w_sel;
            r_a_fg  <= i_fg;
            r_a_bg  <= i_bg;
        end
    end

    // Stage B: t = n + d, always 0..6d, then numerator 60*t + d.
    assign w_d = {{(T_W-CH_W){1'b0}}, r_a_d};

    always_comb begin
        case (r_a_sel)
            MAX_RED: begin
                w_t = {{(T_W-CH_W){1'b0}}, r_a_fg.green} + w_d
                    - {{(T_W-CH_W){1'b0}}, r_a_fg.blue};
            end
            MAX_GREEN: begin
                w_t = {{(T_W-CH_W){1'b0}}, r_a_fg.blue} + {w_d[T_W-2:0], 1'b0} + w_d
                    - {{(T_W-CH_W){1'b0}}, r_a_fg.red};
            end
            default: begin
                w_t = {{(T_W-CH_W){1'b0}}, r_a_fg.red} + {w_d[T_W-3:0], 2'b00} + w_d
                    - {{(T_W-CH_W){1'b0}}, r_a_fg.green};
            end
        endcase
        w_num = {w_t, 6'b0} - {4'b0, w_t, 2'b00} + {{(NUM_W-CH_W){1'b0}}, r_a_d};

        n_b_data        = r_b_data;
        n_b_data.rem    = w_num[NUM_W-1:QUO_W];
        n_b_data.num_lo = w_num[QUO_W-1:0];
        n_b_data.den    = {r_a_d, 1'b0};
        n_b_data.quo    = '0;
        n_b_data.grey   = (r_a_d == '0);
        n_b_data.fg     = r_a_fg;
        n_b_data.bg     = r_a_bg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

>>> src/hwck_div_stage.sv
// ----------------------------------------------------------------------------
// hwck_div_stage
// One stage of the restoring divider: a few quotient bits per stage.
// ----------------------------------------------------------------------------
module hwck_div_stage
    import hwck_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_div_data o_data,
    input  logic      i_ready
);

    logic             r_valid;
    t_div_data        r_data;
    t_div_data        n_data;
    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic [DEN_W-1:0] w_rem;
    logic [QUO_W-1:0] w_lo;
    logic [QUO_W-1:0] w_quo;
    logic             w_ready;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // For each quotient bit of the stage, shift in the next numerator bit and subtract the divisor when it fits.
    always_comb begin
        w_rem   = i_data.rem;
        w_lo    = i_data.num_lo;
        w_quo   = i_data.quo;
        w_shift = '0;
        w_diff  = '0;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            w_shift = {w_rem, w_lo[QUO_W-1]};
            w_lo    = {w_lo[QUO_W-2:0], 1'b0};
            w_diff  = w_shift - {1'b0, i_data.den};
            if (w_shift >= {1'b0, i_data.den}) begin
                w_rem = w_diff[DEN_W-1:0];
                w_quo = {w_quo[QUO_W-2:0], 1'b1};
            end else begin
                w_rem = w_shift[DEN_W-1:0];
                w_quo = {w_quo[QUO_W-2:0], 1'b0};
            end
        end
        n_data        = i_data;
        n_data.rem    = w_rem;
        n_data.num_lo = w_lo;
        n_data.quo    = w_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/hwck_key_back.sv
// ----------------------------------------------------------------------------
// hwck_key_back
// Final stage: hue from quotient, window test, pixel select, output register.
// ----------------------------------------------------------------------------
module hwck_key_back
    import hwck_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_data i_data,
    input  logic [7:0] i_low,
    input  logic [7:0] i_high,
    output logic      o_valid,
    output t_pixel    o_pixel,
    output logic      o_keyed,
    input  logic      i_stall
);

    logic       r_valid;
    t_pixel     r_pixel;
    logic       r_keyed;
    logic [7:0] w_hue;
    logic       w_hit;
    logic       w_ready;

    assign w_ready = !r_valid || !i_stall;
    assign o_ready = w_ready;

    always_comb begin
        if (i_data.grey) begin
            w_hue = '0;
        end else if (i_data.quo < HUE_SHIFT) begin
            w_hue = i_data.quo + (HUE_RANGE - HUE_SHIFT);
        end else begin
            w_hue = i_data.quo - HUE_SHIFT;
        end
        // Wrapped window matches either tail.
        if (i_low > i_high) begin
            w_hit = (w_hue >= i_low) || (w_hue <= i_high);
        end else begin
            w_hit = (w_hue >= i_low) && (w_hue <= i_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_pixel <= w_hit ? i_data.bg : i_data.fg;
            r_keyed <= w_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_keyed = r_keyed;

endmodule

>>> src/hue_window_chroma_key.sv
// ----------------------------------------------------------------------------
// hue_window_chroma_key
// Replaces foreground pixels whose hue falls in a window around the key hue
// with the background pixel at the same position.
//
//   channel   handshake              payload
//   -------   ---------------------  -------------------------------------
//   pixel in  i_valid / o_stall      i_fg_blue/green/red, i_bg_blue/green/red
//   pixel out o_valid / i_stall      o_out_blue/green/red, o_keyed
//   config    i_cfg_we               i_cfg_index, i_cfg_data
//
// One pixel pair enters per clock while o_stall is low. The stages are max/min,
// hue numerator, four divider stages of two quotient bits each, and the window
// compare with the output register. The divider sets the depth.
// Reset (synchronous, active low) empties the pipeline and loads key hue 60,
// tolerance 10. A stall holds each full stage that has no empty stage after
// it, so o_stall rises only when all seven stages hold a pixel.
// ----------------------------------------------------------------------------
module hue_window_chroma_key
    import hwck_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CH_W-1:0]       i_fg_blue,
    input  logic [CH_W-1:0]       i_fg_green,
    input  logic [CH_W-1:0]       i_fg_red,
    input  logic [CH_W-1:0]       i_bg_blue,
    input  logic [CH_W-1:0]       i_bg_green,
    input  logic [CH_W-1:0]       i_bg_red,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CH_W-1:0]       o_out_blue,
    output logic [CH_W-1:0]       o_out_green,
    output logic [CH_W-1:0]       o_out_red,
    output logic                  o_keyed,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers and the window bounds derived from them.
    logic [7:0] r_key_hue;
    logic [6:0] r_hue_tol;
    logic [7:0] r_low;
    logic [7:0] r_high;
    logic [7:0] n_low;
    logic [7:0] n_high;
    logic [7:0] w_key;
    logic [6:0] w_tol;
    logic [8:0] w_sum;
    logic [8:0] w_wrap_low;

    t_pixel    w_fg;
    t_pixel    w_bg;
    t_pixel    w_out_pixel;
    logic      w_front_ready;
    logic      w_back_ready;

    // Index 0 is the front end output, index DIV_STAGES feeds the back end.
    t_div_data              w_div_data  [DIV_STAGES+1];
    logic [DIV_STAGES:0]    w_div_valid;
    logic [DIV_STAGES:0]    w_div_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hue <= KEY_HUE_RST;
            r_hue_tol <= HUE_TOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_HUE: r_key_hue <= i_cfg_data;
                CFG_HUE_TOL: r_hue_tol <= i_cfg_data[6:0];
                default:     r_key_hue <= r_key_hue;
            endcase
        end
    end

    // Fold the key into 0..179, clamp tolerance, then form the bounds mod 180.
    always_comb begin
        w_key      = (r_key_hue >= HUE_RANGE) ? r_key_hue - HUE_RANGE : r_key_hue;
        w_tol      = (r_hue_tol > TOL_MAX) ? TOL_MAX : r_hue_tol;
        w_sum      = {1'b0, w_key} + {2'b0, w_tol};
        w_wrap_low = {1'b0, w_key} + {1'b0, HUE_RANGE} - {2'b0, w_tol};
        if (w_key >= {1'b0, w_tol}) begin
            n_low = w_key - {1'b0, w_tol};
        end else begin
            n_low = w_wrap_low[7:0];
        end
        if (w_sum >= {1'b0, HUE_RANGE}) begin
            n_high = w_sum[7:0] - HUE_RANGE;
        end else begin
            n_high = w_sum[7:0];
        end
    end

    // The user changes config only while idle (not enforced); lag is harmless.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RST;
            r_high <= HIGH_RST;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    assign w_fg    = '{blue: i_fg_blue, green: i_fg_green, red: i_fg_red};
    assign w_bg    = '{blue: i_bg_blue, green: i_bg_green, red: i_bg_red};
    assign o_stall = !w_front_ready;

    hwck_hue_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_front_ready),
        .i_fg    (w_fg),
        .i_bg    (w_bg),
        .o_valid (w_div_valid[0]),
        .o_data  (w_div_data[0]),
        .i_ready (w_div_ready[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        hwck_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_div_valid[s]),
            .o_ready (w_div_ready[s]),
            .i_data  (w_div_data[s]),
            .o_valid (w_div_valid[s+1]),
            .o_data  (w_div_data[s+1]),
            .i_ready (w_div_ready[s+1])
        );
    end

    assign w_div_ready[DIV_STAGES] = w_back_ready;

    hwck_key_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid[DIV_STAGES]),
        .o_ready (w_back_ready),
        .i_data  (w_div_data[DIV_STAGES]),
        .i_low   (r_low),
        .i_high  (r_high),
        .o_valid (o_valid),
        .o_pixel (w_out_pixel),
        .o_keyed (o_keyed),
        .i_stall (i_stall)
    );

    assign o_out_blue  = w_out_pixel.blue;
    assign o_out_green = w_out_pixel.green;
    assign o_out_red   = w_out_pixel.red;

`ifndef ASSERT_OFF
    a_low_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low < HUE_RANGE)
        else $error("window low bound out of hue range");

    a_high_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high < HUE_RANGE)
        else $error("window high bound out of hue range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && (&w_div_valid[DIV_STAGES:1])))
        else $error("input stalled while pipeline has a free stage");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_valid[DIV_STAGES] && !w_div_data[DIV_STAGES].grey)
            |-> (w_div_data[DIV_STAGES].quo <= HUE_RANGE))
        else $error("hue quotient above 180");
`endif

endmodule

>>> bench/hue_window_chroma_key_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hue_window_chroma_key_tb
// Self-checking bench for the hue window chroma key. A directed table covers
// grey pixels, primary and secondary hues, window edges, rounding halves and
// register values above range. Random pixel pairs then run under a series of
// key windows. Transfers in are scored by a behavioral predictor or a table,
// and every transfer out is compared field by field with the oldest score.
// ----------------------------------------------------------------------------
module hue_window_chroma_key_tb;
    import hwck_pkg::*;

    localparam int HUE_SPAN       = 180;  // hue wraps at 180 half-degrees
    localparam int TOL_CAP        = 89;   // widest usable half window
    localparam int N_VECTORS      = 23;
    localparam int N_PHASES       = 13;
    localparam int PHASE_PAIRS    = 100;
    localparam int MAX_GAP        = 8;
    localparam int HOLD_CYCLES    = 60;   // long receiver hold-off
    localparam int DRAIN_SETTLE   = 2;
    localparam int END_SETTLE     = 16;   // pipeline is seven deep
    localparam int WATCHDOG_LIMIT = 500;

    // Composited pixel as it leaves the block.
    typedef struct packed {
        t_pixel pix;
        logic   keyed;
    } t_keyed_px;

    // How a directed row is scored: by the predictor, or typed in as
    // "foreground passes" or "background taken".
    typedef enum logic [1:0] {
        OUT_PREDICT,
        OUT_FG,
        OUT_BG
    } t_outcome;

    // Directed row: register values in force, then the pixel pair.
    // Pixels are written as 24'hBBGGRR.
    typedef struct packed {
        logic [7:0] key;
        logic [7:0] tol;
        t_pixel     fg;
        t_pixel     bg;
        t_outcome   outcome;
    } t_key_vec;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [CH_W-1:0]       i_fg_blue;
    logic [CH_W-1:0]       i_fg_green;
    logic [CH_W-1:0]       i_fg_red;
    logic [CH_W-1:0]       i_bg_blue;
    logic [CH_W-1:0]       i_bg_green;
    logic [CH_W-1:0]       i_bg_red;
    logic                  o_valid;
    logic                  i_stall;
    logic [CH_W-1:0]       o_out_blue;
    logic [CH_W-1:0]       o_out_green;
    logic [CH_W-1:0]       o_out_red;
    logic                  o_keyed;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Bench copy of the two registers, loaded with their reset values.
    logic [7:0] key_hue_cfg = 8'd60;
    logic [6:0] hue_tol_cfg = 7'd10;

    t_keyed_px composite_q[$];   // composited pixels still owed by the block
    int        error_count  = 0;
    int        idle_cycles  = 0;
    bit        steady       = 1'b0;   // no idling on either side
    bit        rx_hold_req  = 1'b0;   // ask the receiver for a long hold-off

    t_key_vec key_vectors [N_VECTORS] = '{
        // reset window 50..70
        '{8'd60,  8'd10,  24'h000000, 24'h123456, OUT_FG},      // black, grey
        '{8'd60,  8'd10,  24'hFFFFFF, 24'h123456, OUT_FG},      // white, grey
        '{8'd60,  8'd10,  24'h00FF00, 24'hA5C3E7, OUT_BG},      // pure green, 60
        '{8'd60,  8'd10,  24'h0000FF, 24'hA5C3E7, OUT_FG},      // pure red, 0
        '{8'd60,  8'd10,  24'hFF0000, 24'hA5C3E7, OUT_FG},      // pure blue, 120
        '{8'd60,  8'd10,  24'h00FF55, 24'h0F0F0F, OUT_PREDICT}, // hue 50, low edge
        '{8'd60,  8'd10,  24'h55FF00, 24'hF0F0F0, OUT_PREDICT}, // hue 70, high edge
        '{8'd60,  8'd10,  24'h00FF5E, 24'h5A5A5A, OUT_PREDICT}, // hue 49, just out
        '{8'd60,  8'd10,  24'h00013C, 24'h777777, OUT_PREDICT}, // +0.5 rounds up
        '{8'd60,  8'd10,  24'h01003C, 24'h777777, OUT_PREDICT}, // -0.5 rounds to 0
        '{8'd60,  8'd10,  24'h0900FF, 24'h3C3C3C, OUT_PREDICT}, // hue 179
        '{8'd60,  8'd10,  24'hFFFF00, 24'h808080, OUT_PREDICT}, // cyan, 90
        '{8'd60,  8'd10,  24'hFF00FF, 24'h808080, OUT_PREDICT}, // magenta, 150
        // single-hue window at 0: grey is keyed
        '{8'd0,   8'd0,   24'h808080, 24'h1D2E3F, OUT_BG},
        '{8'd0,   8'd0,   24'h0900FF, 24'h1D2E3F, OUT_PREDICT},
        // window 90..88 wrapped, only 89 left out
        '{8'd179, 8'd89,  24'hFF0000, 24'hC0FFEE, OUT_PREDICT},
        '{8'd179, 8'd89,  24'hF7FF00, 24'hC0FFEE, OUT_PREDICT},
        // key 200 folds to 20, tolerance 100 saturates: only 110 left out
        '{8'd200, 8'd100, 24'hFF5500, 24'h010203, OUT_PREDICT},
        // register data all ones: key 75, tolerance 127 saturates
        '{8'd255, 8'd255, 24'hFFFFFF, 24'h000000, OUT_PREDICT},
        // zero tolerance at 90
        '{8'd90,  8'd0,   24'hFFFF00, 24'h445566, OUT_PREDICT},
        '{8'd90,  8'd0,   24'hFFFE00, 24'h445566, OUT_PREDICT},
        // tolerance data with bit 7 set: only the low seven bits hold
        '{8'd60,  8'h8A,  24'h00FF00, 24'h998877, OUT_PREDICT},
        // key 180 folds to 0
        '{8'd180, 8'd0,   24'h000000, 24'hABCDEF, OUT_PREDICT}
    };

    hue_window_chroma_key uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_fg_blue   (i_fg_blue),
        .i_fg_green  (i_fg_green),
        .i_fg_red    (i_fg_red),
        .i_bg_blue   (i_bg_blue),
        .i_bg_green  (i_bg_green),
        .i_bg_red    (i_bg_red),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_keyed     (o_keyed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hue of a pixel in half-degree units, 0..179. The sector of the largest
    // channel is picked red first, then green, then blue. The numerator is
    // offset by one sector so it never goes negative; the offset comes back
    // out after the rounded divide.
    function automatic logic [7:0] fg_hue(input t_pixel p);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  span;
        logic [10:0] offs;
        logic [16:0] num;
        logic [8:0]  den;
        logic [7:0]  q;
        hi = p.red;
        lo = p.red;
        if (p.green > hi) hi = p.green;
        if (p.blue > hi)  hi = p.blue;
        if (p.green < lo) lo = p.green;
        if (p.blue < lo)  lo = p.blue;
        span = hi - lo;
        if (span == 8'd0)
            return 8'd0;
        if (hi == p.red)
            offs = p.green + span - p.blue;
        else if (hi == p.green)
            offs = 11'(p.blue + 3 * span - p.red);
        else
            offs = 11'(p.red + 5 * span - p.green);
        // round to nearest, halves upward
        num = 17'(60 * offs + span);
        den = {span, 1'b0};
        q   = 8'(num / den);
        return (q < 8'd30) ? q + 8'd150 : q - 8'd30;
    endfunction

    // Composite one pixel pair under the registers currently loaded.
    function automatic t_keyed_px key_pixel(input t_pixel fg, input t_pixel bg);
        int        key_c;
        int        tol_c;
        int        win_lo;
        int        win_hi;
        int        hue;
        bit        hit;
        t_keyed_px res;
        key_c  = (key_hue_cfg >= HUE_SPAN) ? key_hue_cfg - HUE_SPAN : key_hue_cfg;
        tol_c  = (hue_tol_cfg > TOL_CAP) ? TOL_CAP : hue_tol_cfg;
        win_lo = (key_c + HUE_SPAN - tol_c) % HUE_SPAN;
        win_hi = (key_c + tol_c) % HUE_SPAN;
        hue    = fg_hue(fg);
        // a window that runs past 179 wraps around to 0
        if (win_lo <= win_hi)
            hit = (hue >= win_lo) && (hue <= win_hi);
        else
            hit = (hue >= win_lo) || (hue <= win_hi);
        res.pix   = hit ? bg : fg;
        res.keyed = hit;
        return res;
    endfunction

    // Mix of uniform colors, greys and fully saturated hues; the saturated
    // ones sweep the whole hue circle so every window gets hits.
    function automatic t_pixel rand_pixel();
        t_pixel     p;
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1: begin
                p = '{v, v, v};
            end
            2, 3, 4: begin
                case ($urandom_range(0, 5))
                    0: p = '{8'd255, 8'd0, v};
                    1: p = '{8'd255, v, 8'd0};
                    2: p = '{8'd0, 8'd255, v};
                    3: p = '{v, 8'd255, 8'd0};
                    4: p = '{8'd0, v, 8'd255};
                    default: p = '{v, 8'd0, 8'd255};
                endcase
            end
            default: begin
                p = 24'($urandom);
            end
        endcase
        return p;
    endfunction

    // Offer one pixel pair after a random gap, hold it until the block takes
    // it, then queue the composite it owes. Call right after a rising edge.
    task automatic offer_pair(input t_pixel fg, input t_pixel bg, input t_keyed_px want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_fg_blue  <= fg.blue;
        i_fg_green <= fg.green;
        i_fg_red   <= fg.red;
        i_bg_blue  <= bg.blue;
        i_bg_green <= bg.green;
        i_bg_red   <= bg.red;
        do @(posedge i_clk); while (o_stall);
        composite_q.push_back(want);
    endtask

    // Drop valid and hold off until every owed composite has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (composite_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Write key hue, then tolerance, on back-to-back edges. Only call while
    // the pipeline is empty.
    task automatic load_window(input logic [7:0] key_data, input logic [7:0] tol_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KEY_HUE;
        i_cfg_data  <= key_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_HUE_TOL;
        i_cfg_data  <= tol_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        key_hue_cfg = key_data;
        hue_tol_cfg = tol_data[6:0];
    endtask

    task automatic flag_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Stimulus: directed table first, then random phases under changing
    // windows. Registers only change with the pipeline empty.
    initial begin
        t_keyed_px  want;
        t_pixel     fg;
        t_pixel     bg;
        logic [7:0] key_data;
        logic [7:0] tol_data;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_fg_blue   = '0;
        i_fg_green  = '0;
        i_fg_red    = '0;
        i_bg_blue   = '0;
        i_bg_green  = '0;
        i_bg_red    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_KEY_HUE;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first rows run on the reset values; reload only when a row
        // asks for a different window.
        foreach (key_vectors[i]) begin
            if (key_vectors[i].key != key_hue_cfg
                    || key_vectors[i].tol[6:0] != hue_tol_cfg) begin
                wait_drained();
                load_window(key_vectors[i].key, key_vectors[i].tol);
            end
            case (key_vectors[i].outcome)
                OUT_FG:  want = '{key_vectors[i].fg, 1'b0};
                OUT_BG:  want = '{key_vectors[i].bg, 1'b1};
                default: want = key_pixel(key_vectors[i].fg, key_vectors[i].bg);
            endcase
            offer_pair(key_vectors[i].fg, key_vectors[i].bg, want);
        end

        // Random phases: extremes first, then random windows. Some phases
        // run without idling; one of them also asks the receiver for a long
        // hold-off so the pipeline fills and pushes back.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    key_data = 8'd0;
                    tol_data = 8'd0;
                end
                1: begin
                    key_data = 8'd179;
                    tol_data = 8'd89;
                end
                2: begin
                    key_data = 8'd255;
                    tol_data = 8'd255;
                end
                3: begin
                    key_data = 8'd180;
                    tol_data = 8'd90;
                end
                default: begin
                    key_data = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(180, 255))
                                                           : 8'($urandom_range(0, 179));
                    tol_data = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(90, 255))
                                                           : 8'($urandom_range(0, 89));
                end
            endcase
            wait_drained();
            load_window(key_data, tol_data);
            steady = (ph % 4 == 2) || (ph == 7);
            if (ph == 7)
                rx_hold_req = 1'b1;
            repeat (PHASE_PAIRS) begin
                fg = rand_pixel();
                bg = 24'($urandom);
                offer_pair(fg, bg, key_pixel(fg, bg));
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: stall a random number of cycles before each transfer out,
    // or hold off for a long stretch when asked.
    initial begin
        int pause;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            pause = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (pause > 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Score every transfer out against the oldest owed composite.
    always @(posedge i_clk) begin
        t_keyed_px want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (composite_q.size() == 0) begin
                $display("%0t ns: unexpected output b %0d g %0d r %0d keyed %0d",
                         $time, o_out_blue, o_out_green, o_out_red, o_keyed);
                error_count++;
            end else begin
                want = composite_q.pop_front();
                flag_field("o_out_blue",  want.pix.blue,  o_out_blue);
                flag_field("o_out_green", want.pix.green, o_out_green);
                flag_field("o_out_red",   want.pix.red,   o_out_red);
                flag_field("o_keyed",     {7'b0, want.keyed}, {7'b0, o_keyed});
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

>>> files.f
src/hwck_pkg.sv
src/hwck_hue_front.sv
src/hwck_div_stage.sv
src/hwck_key_back.sv
src/hue_window_chroma_key.sv
bench/hue_window_chroma_key_tb.sv
